[hdl/homogeneous_transform_unit_macros.svh]
// Assertion macros shared by the transform unit.
// Every macro samples on the rising edge of clk and is switched off while rst is high.
`ifndef HOMOGENEOUS_TRANSFORM_UNIT_MACROS_SVH
`define HOMOGENEOUS_TRANSFORM_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HTU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/htu_pkg.sv]
package htu_pkg;

  localparam int ARG_W  = 32;
  localparam int OPB_W  = ARG_W + 1;      // second multiplier operand, holds a negated sine
  localparam int PROD_W = ARG_W + OPB_W;
  localparam int DIM    = 4;
  localparam int DATA_W = DIM * ARG_W;
  localparam int USER_W = 3;

  typedef logic signed [ARG_W-1:0] word_t;

  typedef enum logic [USER_W-1:0] {
    OP_IDENTITY  = 3'd0,
    OP_ROT_X     = 3'd1,
    OP_ROT_Y     = 3'd2,
    OP_ROT_Z     = 3'd3,
    OP_SCALE     = 3'd4,
    OP_TRANSLATE = 3'd5,
    OP_TRANSPOSE = 3'd6,
    OP_VECTOR    = 3'd7
  } opcode_t;

  // Load strobe and operation travelling with one pipeline stage.
  typedef struct packed {
    logic    go;
    opcode_t op;
  } stage_ctrl_t;

endpackage

[hdl/htu_prod.sv]
// Product stage: picks operand pairs from the matrix and the request, multiplies,
// floors by the fraction shift and registers the sixteen results.
module htu_prod #(
  parameter int FRAC_BITS = 16,
  localparam int Q_W = htu_pkg::PROD_W - FRAC_BITS
) (
  input  logic                 clk,
  input  htu_pkg::stage_ctrl_t ctrl,
  input  htu_pkg::word_t       arg_a,
  input  htu_pkg::word_t       arg_b,
  input  htu_pkg::word_t       arg_c,
  input  htu_pkg::word_t       arg_d,
  input  htu_pkg::word_t       mat [htu_pkg::DIM][htu_pkg::DIM],
  output logic signed [Q_W-1:0] q  [htu_pkg::DIM][htu_pkg::DIM]
);

  localparam logic signed [htu_pkg::OPB_W-1:0] ONE_B =
    htu_pkg::OPB_W'(1) << FRAC_BITS;

  logic signed [htu_pkg::OPB_W-1:0]  pos_a, pos_b, pos_c, pos_d, neg_b;
  htu_pkg::word_t                    opa  [htu_pkg::DIM][htu_pkg::DIM];
  logic signed [htu_pkg::OPB_W-1:0]  opb  [htu_pkg::DIM][htu_pkg::DIM];
  logic signed [htu_pkg::PROD_W-1:0] prod [htu_pkg::DIM][htu_pkg::DIM];

  assign pos_a = htu_pkg::OPB_W'(arg_a);
  assign pos_b = htu_pkg::OPB_W'(arg_b);
  assign pos_c = htu_pkg::OPB_W'(arg_c);
  assign pos_d = htu_pkg::OPB_W'(arg_d);
  // Negated at full width so that the most negative sine stays exact.
  assign neg_b = -pos_b;

  // Each row uses its own four multipliers; the update stage knows which sums to form.
  always_comb begin
    for (int r = 0; r < htu_pkg::DIM; r++) begin
      for (int k = 0; k < htu_pkg::DIM; k++) begin
        opa[r][k] = '0;
        opb[r][k] = '0;
      end
      unique case (ctrl.op)
        htu_pkg::OP_ROT_X: begin
          opa[r][0] = mat[r][1]; opb[r][0] = pos_a;
          opa[r][1] = mat[r][2]; opb[r][1] = pos_b;
          opa[r][2] = mat[r][1]; opb[r][2] = neg_b;
          opa[r][3] = mat[r][2]; opb[r][3] = pos_a;
        end
        htu_pkg::OP_ROT_Y: begin
          opa[r][0] = mat[r][0]; opb[r][0] = pos_a;
          opa[r][1] = mat[r][2]; opb[r][1] = neg_b;
          opa[r][2] = mat[r][0]; opb[r][2] = pos_b;
          opa[r][3] = mat[r][2]; opb[r][3] = pos_a;
        end
        htu_pkg::OP_ROT_Z: begin
          opa[r][0] = mat[r][0]; opb[r][0] = pos_a;
          opa[r][1] = mat[r][1]; opb[r][1] = pos_b;
          opa[r][2] = mat[r][0]; opb[r][2] = neg_b;
          opa[r][3] = mat[r][1]; opb[r][3] = pos_a;
        end
        htu_pkg::OP_SCALE, htu_pkg::OP_TRANSLATE: begin
          opa[r][0] = mat[r][0]; opb[r][0] = pos_a;
          opa[r][1] = mat[r][1]; opb[r][1] = pos_b;
          opa[r][2] = mat[r][2]; opb[r][2] = pos_c;
          opa[r][3] = mat[r][3]; opb[r][3] = ONE_B;
        end
        htu_pkg::OP_VECTOR: begin
          opa[r][0] = mat[r][0]; opb[r][0] = pos_a;
          opa[r][1] = mat[r][1]; opb[r][1] = pos_b;
          opa[r][2] = mat[r][2]; opb[r][2] = pos_c;
          opa[r][3] = mat[r][3]; opb[r][3] = pos_d;
        end
        htu_pkg::OP_IDENTITY, htu_pkg::OP_TRANSPOSE: begin
          // No products needed.
        end
      endcase
      for (int k = 0; k < htu_pkg::DIM; k++) begin
        prod[r][k] = htu_pkg::PROD_W'(opa[r][k]) * htu_pkg::PROD_W'(opb[r][k]);
      end
    end
  end

  // Arithmetic shift right rounds towards negative infinity.
  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      for (int r = 0; r < htu_pkg::DIM; r++) begin
        for (int k = 0; k < htu_pkg::DIM; k++) begin
          q[r][k] <= Q_W'(prod[r][k] >>> FRAC_BITS);
        end
      end
    end
  end

endmodule

[hdl/htu_update.sv]
// Update stage: adds the floored products, saturates, and holds the current matrix.
module htu_update #(
  parameter int FRAC_BITS = 16,
  localparam int Q_W = htu_pkg::PROD_W - FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  htu_pkg::stage_ctrl_t  ctrl,
  input  logic signed [Q_W-1:0] q   [htu_pkg::DIM][htu_pkg::DIM],
  output htu_pkg::word_t        mat [htu_pkg::DIM][htu_pkg::DIM],
  output htu_pkg::word_t        vec [htu_pkg::DIM]
);

  localparam int S_W = Q_W + 2;
  localparam logic signed [S_W-1:0] S_MAX =
    {{(S_W - htu_pkg::ARG_W + 1){1'b0}}, {(htu_pkg::ARG_W - 1){1'b1}}};
  localparam logic signed [S_W-1:0] S_MIN =
    {{(S_W - htu_pkg::ARG_W + 1){1'b1}}, {(htu_pkg::ARG_W - 1){1'b0}}};
  localparam htu_pkg::word_t ONE_W = htu_pkg::word_t'(1) << FRAC_BITS;

  function automatic htu_pkg::word_t sat(input logic signed [S_W-1:0] v);
    htu_pkg::word_t res;
    if (v > S_MAX) begin
      res = S_MAX[htu_pkg::ARG_W-1:0];
    end else if (v < S_MIN) begin
      res = S_MIN[htu_pkg::ARG_W-1:0];
    end else begin
      res = v[htu_pkg::ARG_W-1:0];
    end
    return res;
  endfunction

  logic signed [S_W-1:0] qe   [htu_pkg::DIM][htu_pkg::DIM];
  logic signed [S_W-1:0] s01  [htu_pkg::DIM];
  logic signed [S_W-1:0] s23  [htu_pkg::DIM];
  logic signed [S_W-1:0] sall [htu_pkg::DIM];
  htu_pkg::word_t        mat_next [htu_pkg::DIM][htu_pkg::DIM];

  always_comb begin
    for (int r = 0; r < htu_pkg::DIM; r++) begin
      for (int k = 0; k < htu_pkg::DIM; k++) begin
        qe[r][k] = S_W'(q[r][k]);
      end
      s01[r]  = qe[r][0] + qe[r][1];
      s23[r]  = qe[r][2] + qe[r][3];
      sall[r] = s01[r] + s23[r];
      vec[r]  = sat(sall[r]);
    end
  end

  // Terms of the right-hand matrix equal to one pass the old element through unchanged.
  always_comb begin
    for (int r = 0; r < htu_pkg::DIM; r++) begin
      for (int k = 0; k < htu_pkg::DIM; k++) begin
        mat_next[r][k] = mat[r][k];
      end
      unique case (ctrl.op)
        htu_pkg::OP_IDENTITY: begin
          for (int k = 0; k < htu_pkg::DIM; k++) begin
            mat_next[r][k] = (r == k) ? ONE_W : '0;
          end
        end
        htu_pkg::OP_TRANSPOSE: begin
          for (int k = 0; k < htu_pkg::DIM; k++) begin
            mat_next[r][k] = mat[k][r];
          end
        end
        htu_pkg::OP_ROT_X: begin
          mat_next[r][1] = sat(s01[r]);
          mat_next[r][2] = sat(s23[r]);
        end
        htu_pkg::OP_ROT_Y: begin
          mat_next[r][0] = sat(s01[r]);
          mat_next[r][2] = sat(s23[r]);
        end
        htu_pkg::OP_ROT_Z: begin
          mat_next[r][0] = sat(s01[r]);
          mat_next[r][1] = sat(s23[r]);
        end
        htu_pkg::OP_SCALE: begin
          mat_next[r][0] = sat(qe[r][0]);
          mat_next[r][1] = sat(qe[r][1]);
          mat_next[r][2] = sat(qe[r][2]);
        end
        htu_pkg::OP_TRANSLATE: begin
          mat_next[r][3] = sat(sall[r]);
        end
        htu_pkg::OP_VECTOR: begin
          // Matrix unchanged.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < htu_pkg::DIM; r++) begin
      for (int k = 0; k < htu_pkg::DIM; k++) begin
        if (rst) begin
          mat[r][k] <= (r == k) ? ONE_W : '0;
        end else if (ctrl.go) begin
          mat[r][k] <= mat_next[r][k];
        end
      end
    end
  end

endmodule

[hdl/homogeneous_transform_unit.sv]
// Channel  | Direction | Signals                        | Contents
// ---------+-----------+--------------------------------+----------------------------------------
// s_axis   | in        | tvalid, tready, tdata, tuser   | one request: opcode and four Q arguments
// m_axis   | out       | tvalid, tready, tdata          | one transformed vector per opcode 7
//
// A request passes through three registers: the input register, the product register and
// either the matrix (for opcodes 0 to 6) or the output register (opcode 7).
// Vector requests stream at one per clock while m_axis_tready is high. A request that
// changes the matrix holds the request behind it in the input register while it sits in
// the product stage, because the sixteen multipliers read the matrix that this request writes.
// Reset is synchronous; it empties the pipeline and loads the identity matrix.
// A stalled output holds only the output register: the earlier stages keep taking requests
// until they, too, are full.

`include "homogeneous_transform_unit_macros.svh"

module homogeneous_transform_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // arg_a [31:0], arg_b [63:32], arg_c [95:64], arg_d [127:96]
  input  logic [htu_pkg::DATA_W-1:0]   s_axis_tdata,
  // opcode [2:0]
  input  logic [htu_pkg::USER_W-1:0]   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // out_x [31:0], out_y [63:32], out_z [95:64], out_w [127:96]
  output logic [htu_pkg::DATA_W-1:0]   m_axis_tdata
);

  localparam int AW  = htu_pkg::ARG_W;
  localparam int Q_W = htu_pkg::PROD_W - FRAC_BITS;

  // Input register: the accepted request waits here until the product stage is free.
  logic             in_valid;
  htu_pkg::opcode_t in_op;
  htu_pkg::word_t   in_a, in_b, in_c, in_d;

  // Product register: only the control lives here, the products sit inside htu_prod.
  logic             mid_valid;
  htu_pkg::opcode_t mid_op;

  // Output register.
  logic                       out_valid;
  logic [htu_pkg::DATA_W-1:0] out_data;

  logic                 s_accept;
  logic                 out_free;
  logic                 mid_is_mat;
  logic                 mid_go;
  logic                 mid_free;
  logic                 in_go;
  htu_pkg::stage_ctrl_t prod_ctrl;
  htu_pkg::stage_ctrl_t upd_ctrl;

  logic signed [Q_W-1:0] q   [htu_pkg::DIM][htu_pkg::DIM];
  htu_pkg::word_t        mat [htu_pkg::DIM][htu_pkg::DIM];
  htu_pkg::word_t        vec [htu_pkg::DIM];

  // The output register may be refilled in the same cycle as its result is taken.
  assign out_free   = !out_valid || m_axis_tready;
  // A matrix request in the product stage leaves the next request waiting, since the
  // matrix it writes is not yet visible to the multipliers.
  assign mid_is_mat = mid_valid && (mid_op != htu_pkg::OP_VECTOR);
  assign mid_go     = mid_valid && ((mid_op != htu_pkg::OP_VECTOR) || out_free);
  assign mid_free   = !mid_valid || mid_go;
  assign in_go      = in_valid && mid_free && !mid_is_mat;

  assign s_axis_tready = !in_valid || in_go;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign prod_ctrl = '{go: in_go,  op: in_op};
  assign upd_ctrl  = '{go: mid_go, op: mid_op};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_accept) begin
        in_valid <= 1'b1;
      end else if (in_go) begin
        in_valid <= 1'b0;
      end
      if (in_go) begin
        mid_valid <= 1'b1;
      end else if (mid_go) begin
        mid_valid <= 1'b0;
      end
      if (mid_go && (mid_op == htu_pkg::OP_VECTOR)) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset; the valid flags above qualify them.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_op <= htu_pkg::opcode_t'(s_axis_tuser);
      in_a  <= s_axis_tdata[0*AW +: AW];
      in_b  <= s_axis_tdata[1*AW +: AW];
      in_c  <= s_axis_tdata[2*AW +: AW];
      in_d  <= s_axis_tdata[3*AW +: AW];
    end
    if (in_go) begin
      mid_op <= in_op;
    end
    if (mid_go && (mid_op == htu_pkg::OP_VECTOR)) begin
      out_data <= {vec[3], vec[2], vec[1], vec[0]};
    end
  end

  htu_prod #(
    .FRAC_BITS(FRAC_BITS)
  ) u_prod (
    .clk   (clk),
    .ctrl  (prod_ctrl),
    .arg_a (in_a),
    .arg_b (in_b),
    .arg_c (in_c),
    .arg_d (in_d),
    .mat   (mat),
    .q     (q)
  );

  htu_update #(
    .FRAC_BITS(FRAC_BITS)
  ) u_update (
    .clk  (clk),
    .rst  (rst),
    .ctrl (upd_ctrl),
    .q    (q),
    .mat  (mat),
    .vec  (vec)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // A matrix request never waits in the product stage, and nothing follows it in directly.
  `HTU_ASSERT_NEXT(a_mat_req_leaves, mid_is_mat, !mid_valid, "matrix request lingered")
  // A fresh result can only come from a vector request that was in the product stage.
  `HTU_ASSERT_SAME(a_out_src, $rose(out_valid), $past(mid_valid && !mid_is_mat), "stray result")
  // A request moved on from the input register always lands in the product stage.
  `HTU_ASSERT_NEXT(a_no_lost_request, in_go, mid_valid, "request lost between stages")

endmodule
